// ----- rtl/two_queue_weighted_service_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Two-queue weighted service unit: assertion macros
// Shared concurrent assertion forms, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TWO_QUEUE_WEIGHTED_SERVICE_UNIT_MACROS_SVH
`define TWO_QUEUE_WEIGHTED_SERVICE_UNIT_MACROS_SVH

// Same-cycle implication.
`define TQWS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tqws assertion failed");

// Next-cycle implication.
`define TQWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tqws assertion failed");

`endif

// ----- rtl/tqws_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-queue weighted service unit: package
// Shared sizes, codes, command word type and the counter reduction table.
// ----------------------------------------------------------------------------
package tqws_pkg;

    localparam int Q_DEPTH = 16;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    localparam int DATA_W     = 32;
    localparam int PERIOD_W   = 5;
    localparam int CTR_W      = 4;
    localparam int PERIOD_MAX = 16;
    localparam int LUT_N      = (1 << CTR_W) * PERIOD_MAX;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(4);
    localparam logic [CTR_W-1:0]    CTR_RESET    = CTR_W'(1);

    localparam logic [1:0] FUNC_ENQ_NORM = 2'd0;
    localparam logic [1:0] FUNC_ENQ_PREF = 2'd1;

    localparam logic FROM_NORM = 1'b0;
    localparam logic FROM_PREF = 1'b1;

    typedef enum logic [1:0] {
        K_ENQ_NORM,
        K_ENQ_PREF,
        K_SERVE
    } t_kind;

    typedef enum logic [1:0] {
        ST_ENQUEUED = 2'd0,
        ST_DROPPED  = 2'd1,
        ST_SERVED   = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic {
        BS_IDLE,
        BS_READ
    } t_back_state;

    typedef struct packed {
        t_kind                    kind;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // Entry {counter, period - 1} holds counter modulo period.
    typedef logic [CTR_W-1:0] t_lut [LUT_N];

    function automatic t_lut build_mod_lut();
        t_lut             lut;
        logic [CTR_W-1:0] r;
        for (int p = 0; p < PERIOD_MAX; p++) begin
            r = '0;
            for (int c = 0; c < (1 << CTR_W); c++) begin
                lut[c * PERIOD_MAX + p] = r;
                r = (r == CTR_W'(p)) ? '0 : r + CTR_W'(1);
            end
        end
        return lut;
    endfunction

    localparam t_lut MOD_LUT = build_mod_lut();

endpackage

// ----- rtl/tqws_if.sv -----
// ----------------------------------------------------------------------------
// Two-queue weighted service unit: channel interfaces
// Input, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface tqws_in_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          func;
    logic signed [tqws_pkg::DATA_W-1:0] value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface tqws_out_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [tqws_pkg::DATA_W-1:0] served_value;
    logic                                served_from;

    modport source (output valid, output status, output served_value,
                    output served_from, input ready);
    modport sink   (input valid, input status, input served_value,
                    input served_from, output ready);
endinterface

interface tqws_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tqws_pkg::PERIOD_W-1:0]  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/tqws_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tqws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/tqws_front.sv -----
// ----------------------------------------------------------------------------
// Two-queue weighted service unit: front end
// Accepts input words, decodes the function and buffers two commands.
// ----------------------------------------------------------------------------
module tqws_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tqws_in_if.sink        i_in,
    output tqws_pkg::t_cmd o_cmd,
    output logic           o_cmd_valid,
    input  logic           i_cmd_ready
);

    tqws_pkg::t_cmd r_slot [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_fill;

    tqws_pkg::t_kind w_kind;
    logic            w_push;
    logic            w_pop;

    always_comb begin
        unique case (i_in.func)
            tqws_pkg::FUNC_ENQ_NORM: w_kind = tqws_pkg::K_ENQ_NORM;
            tqws_pkg::FUNC_ENQ_PREF: w_kind = tqws_pkg::K_ENQ_PREF;
            default:                 w_kind = tqws_pkg::K_SERVE;
        endcase
    end

    assign i_in.ready  = (r_fill != 2'd2);
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= '{kind: w_kind, value: i_in.value};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_fill <= r_fill + 2'd1;
            end else if (!w_push && w_pop) begin
                r_fill <= r_fill - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/tqws_back.sv -----
// ----------------------------------------------------------------------------
// Two-queue weighted service unit: back end
// Holds both ring stores, applies the weighted service policy and keeps
// the result register.
// ----------------------------------------------------------------------------
module tqws_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [tqws_pkg::PERIOD_W-1:0]     i_period,
    input  tqws_pkg::t_cmd                    i_cmd,
    input  logic                              i_cmd_valid,
    output logic                              o_cmd_ready,
    tqws_out_if.source                        o_out
);

    localparam int AW = tqws_pkg::Q_AW;
    localparam int CW = tqws_pkg::Q_CW;
    localparam int DW = tqws_pkg::DATA_W;
    localparam int PW = tqws_pkg::PERIOD_W;
    localparam int TW = tqws_pkg::CTR_W;

    tqws_pkg::t_back_state r_state, n_state;
    logic [AW-1:0]         r_n_head, n_n_head, r_p_head, n_p_head;
    logic [CW-1:0]         r_n_cnt, n_n_cnt, r_p_cnt, n_p_cnt;
    logic [TW-1:0]         r_ctr, n_ctr;
    logic                  r_from, n_from;
    logic                  r_out_valid, n_out_valid;
    tqws_pkg::t_status     r_out_status, n_out_status;
    logic signed [DW-1:0]  r_out_value, n_out_value;
    logic                  r_out_from, n_out_from;

    logic [TW-1:0] w_eff_m1;
    logic [TW-1:0] w_ctr_mod;
    logic [TW-1:0] w_ctr_adv;
    logic          w_slot_free;
    logic          w_has_n, w_has_p;
    logic [AW-1:0] w_n_tail, w_p_tail;
    logic          w_wr_n, w_wr_p, w_rd_n, w_rd_p;
    logic [DW-1:0] w_rd_data_n, w_rd_data_p;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(tqws_pkg::Q_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    function automatic logic [AW-1:0] tail_of(input logic [AW-1:0] h,
                                              input logic [CW-1:0] c);
        logic [CW:0] sum;
        sum = {{(CW + 1 - AW){1'b0}}, h} + {1'b0, c};
        if (sum >= (CW + 1)'(tqws_pkg::Q_DEPTH)) begin
            sum = sum - (CW + 1)'(tqws_pkg::Q_DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    // Period zero or one acts as one, anything above the maximum saturates.
    always_comb begin
        if (i_period <= PW'(1)) begin
            w_eff_m1 = '0;
        end else if (i_period >= PW'(tqws_pkg::PERIOD_MAX)) begin
            w_eff_m1 = TW'(tqws_pkg::PERIOD_MAX - 1);
        end else begin
            w_eff_m1 = TW'(i_period - PW'(1));
        end
    end

    // The counter may exceed a period that was lowered later, so reduce it.
    assign w_ctr_mod = tqws_pkg::MOD_LUT[{r_ctr, w_eff_m1}];
    assign w_ctr_adv = (w_ctr_mod == w_eff_m1) ? '0 : w_ctr_mod + TW'(1);

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_has_n     = (r_n_cnt != '0);
    assign w_has_p     = (r_p_cnt != '0);
    assign w_n_tail    = tail_of(r_n_head, r_n_cnt);
    assign w_p_tail    = tail_of(r_p_head, r_p_cnt);

    always_comb begin
        n_state      = r_state;
        n_n_head     = r_n_head;
        n_n_cnt      = r_n_cnt;
        n_p_head     = r_p_head;
        n_p_cnt      = r_p_cnt;
        n_ctr        = r_ctr;
        n_from       = r_from;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_from   = r_out_from;
        o_cmd_ready  = 1'b0;
        w_wr_n       = 1'b0;
        w_wr_p       = 1'b0;
        w_rd_n       = 1'b0;
        w_rd_p       = 1'b0;

        unique case (r_state)
            tqws_pkg::BS_IDLE: begin
                o_cmd_ready = w_slot_free;
                if (i_cmd_valid && w_slot_free) begin
                    unique case (i_cmd.kind)
                        tqws_pkg::K_ENQ_NORM: begin
                            n_out_valid = 1'b1;
                            n_out_value = '0;
                            n_out_from  = tqws_pkg::FROM_NORM;
                            if (r_n_cnt == CW'(tqws_pkg::Q_DEPTH)) begin
                                n_out_status = tqws_pkg::ST_DROPPED;
                            end else begin
                                n_out_status = tqws_pkg::ST_ENQUEUED;
                                w_wr_n       = 1'b1;
                                n_n_cnt      = r_n_cnt + CW'(1);
                            end
                        end
                        tqws_pkg::K_ENQ_PREF: begin
                            n_out_valid = 1'b1;
                            n_out_value = '0;
                            n_out_from  = tqws_pkg::FROM_NORM;
                            if (r_p_cnt == CW'(tqws_pkg::Q_DEPTH)) begin
                                n_out_status = tqws_pkg::ST_DROPPED;
                            end else begin
                                n_out_status = tqws_pkg::ST_ENQUEUED;
                                w_wr_p       = 1'b1;
                                n_p_cnt      = r_p_cnt + CW'(1);
                            end
                        end
                        default: begin
                            if (!w_has_n && !w_has_p) begin
                                n_ctr        = tqws_pkg::CTR_RESET;
                                n_out_valid  = 1'b1;
                                n_out_status = tqws_pkg::ST_EMPTY;
                                n_out_value  = '0;
                                n_out_from   = tqws_pkg::FROM_NORM;
                            end else begin
                                // Pick the queue, start the store read and
                                // retire the head now; the word follows.
                                if (!w_has_p) begin
                                    n_from = tqws_pkg::FROM_NORM;
                                    n_ctr  = tqws_pkg::CTR_RESET;
                                end else if (!w_has_n) begin
                                    n_from = tqws_pkg::FROM_PREF;
                                    n_ctr  = tqws_pkg::CTR_RESET;
                                end else begin
                                    n_from = (w_ctr_mod == '0) ? tqws_pkg::FROM_NORM
                                                               : tqws_pkg::FROM_PREF;
                                    n_ctr  = w_ctr_adv;
                                end
                                if (n_from == tqws_pkg::FROM_NORM) begin
                                    w_rd_n   = 1'b1;
                                    n_n_head = ptr_inc(r_n_head);
                                    n_n_cnt  = r_n_cnt - CW'(1);
                                end else begin
                                    w_rd_p   = 1'b1;
                                    n_p_head = ptr_inc(r_p_head);
                                    n_p_cnt  = r_p_cnt - CW'(1);
                                end
                                n_state = tqws_pkg::BS_READ;
                            end
                        end
                    endcase
                end
            end
            tqws_pkg::BS_READ: begin
                // The result slot was free when the read was issued.
                n_out_valid  = 1'b1;
                n_out_status = tqws_pkg::ST_SERVED;
                n_out_value  = (r_from == tqws_pkg::FROM_PREF) ? w_rd_data_p
                                                               : w_rd_data_n;
                n_out_from   = r_from;
                n_state      = tqws_pkg::BS_IDLE;
            end
            default: begin
                n_state = tqws_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tqws_pkg::BS_IDLE;
            r_n_head    <= '0;
            r_n_cnt     <= '0;
            r_p_head    <= '0;
            r_p_cnt     <= '0;
            r_ctr       <= tqws_pkg::CTR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n_head    <= n_n_head;
            r_n_cnt     <= n_n_cnt;
            r_p_head    <= n_p_head;
            r_p_cnt     <= n_p_cnt;
            r_ctr       <= n_ctr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_from       <= n_from;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_from   <= n_out_from;
    end

    tqws_ram #(
        .WIDTH (DW),
        .DEPTH (tqws_pkg::Q_DEPTH)
    ) u_norm_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_n),
        .i_wr_addr (w_n_tail),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (w_rd_n),
        .i_rd_addr (r_n_head),
        .o_rd_data (w_rd_data_n)
    );

    tqws_ram #(
        .WIDTH (DW),
        .DEPTH (tqws_pkg::Q_DEPTH)
    ) u_pref_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_p),
        .i_wr_addr (w_p_tail),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (w_rd_p),
        .i_rd_addr (r_p_head),
        .o_rd_data (w_rd_data_p)
    );

    assign o_out.valid        = r_out_valid;
    assign o_out.status       = r_out_status;
    assign o_out.served_value = r_out_value;
    assign o_out.served_from  = r_out_from;

endmodule

// ----- rtl/two_queue_weighted_service_unit.sv -----
// An input word is held in the command buffer; an enqueue, or a serve on empty queues, then
// sets the result register, and a serve that removes a word sets it after the store read.
// Throughput: enqueues retire at one per cycle while results are taken; a serve that removes a
// word holds the back end in its read state for the registered read of the queue store.
// A two-word command buffer lets input words be taken while a result waits to be taken.
// Reset is synchronous, active low: both queues empty, counter 1, period 4; no clearing pass.
// ----------------------------------------------------------------------------
// Two-queue weighted service unit: top level
// Holds the period register and joins the front end to the service back end.
// ----------------------------------------------------------------------------
`include "two_queue_weighted_service_unit_macros.svh"

module two_queue_weighted_service_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tqws_in_if.sink     i_in,
    tqws_cfg_if.sink    i_cfg,
    tqws_out_if.source  o_out
);

    logic [tqws_pkg::PERIOD_W-1:0] r_period;
    tqws_pkg::t_cmd                w_cmd;
    logic                          w_cmd_valid;
    logic                          w_cmd_ready;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= tqws_pkg::PERIOD_RESET;
        end else if (i_cfg.valid) begin
            r_period <= i_cfg.data;
        end
    end

    tqws_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_ready (w_cmd_ready)
    );

    tqws_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_period    (r_period),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_ready (w_cmd_ready),
        .o_out       (o_out)
    );

    // Only a served word carries a value and a source queue.
    `TQWS_ASSERT_NOW(a_unserved_zero,
        o_out.valid && (o_out.status != tqws_pkg::ST_SERVED),
        (o_out.served_value == '0) && (o_out.served_from == 1'b0))

    // A full command buffer always offers a command to the back end.
    `TQWS_ASSERT_NOW(a_full_buffer_offers, !i_in.ready, w_cmd_valid)

    // A taken enqueue command always yields a result on the next cycle.
    `TQWS_ASSERT_NEXT(a_cmd_take_fills_slot,
        w_cmd_valid && w_cmd_ready && (w_cmd.kind != tqws_pkg::K_SERVE),
        o_out.valid)

endmodule
